### src/pbsd_pkg.sv
// Package for the archive byte stream decryptor.
// Holds command and register codes, key table sizes and the constant
// modulo helpers; no dependencies.
package pbsd_pkg;

   localparam int KEY_BYTES    = 16;
   localparam int KEY_IDX_W    = $clog2(KEY_BYTES);
   localparam int KEY_BITS     = 8 * KEY_BYTES;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 3;
   localparam int NUM_W        = 7;

   localparam logic [KEY_IDX_W-1:0] INDEX_A_START = KEY_IDX_W'(0);
   localparam logic [KEY_IDX_W-1:0] INDEX_B_START = KEY_IDX_W'(8);
   localparam logic [KEY_IDX_W:0]   INDEX_A_LIMIT = (KEY_IDX_W+1)'(15);
   localparam logic [KEY_IDX_W:0]   INDEX_B_WRAP  = (KEY_IDX_W+1)'(12);
   localparam logic [KEY_IDX_W:0]   INDEX_B_HOLD  = (KEY_IDX_W+1)'(8);
   localparam logic [NUM_W-1:0]     NUM_STEP      = NUM_W'(2);

   typedef enum logic [1:0] {
      CMD_DECRYPT = 2'd0,
      CMD_SKIP    = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_NONE    = 2'd3
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_A_LOW      = 3'd0,
      CSR_KEY_A_HIGH     = 3'd1,
      CSR_KEY_B_LOW      = 3'd2,
      CSR_KEY_B_HIGH     = 3'd3,
      CSR_START_INDEX    = 3'd4,
      CSR_ENCRYPT_ENABLE = 3'd5
   } csr_index_type;

   // n mod 7 for 7-bit n: quotient = (n * 147) >> 10, exact below 128
   function automatic logic [2:0] mod7(input logic [NUM_W-1:0] n);
      logic [14:0] prod;
      logic [4:0]  quo;
      logic [7:0]  rem;
      prod = 15'(n) * 15'd147;
      quo  = prod[14:10];
      rem  = 8'(n) - 8'(quo) * 8'd7;
      return rem[2:0];
   endfunction

   // n mod 12 for 7-bit n: quotient = (n * 43) >> 9, exact below 128
   function automatic logic [3:0] mod12(input logic [NUM_W-1:0] n);
      logic [12:0] prod;
      logic [3:0]  quo;
      logic [7:0]  rem;
      prod = 13'(n) * 13'd43;
      quo  = prod[12:9];
      rem  = 8'(n) - 8'(quo) * 8'd12;
      return rem[3:0];
   endfunction

endpackage

### src/pack_byte_stream_decryptor_core.sv
// Archive byte stream decryptor, top level.
// Depends on pbsd_pkg for codes, sizes and the modulo helpers.
//
// Usage:
//   Requests enter on req_valid/req_ready with req_command and
//   req_cipher_byte. A decrypt request yields one response on
//   rsp_valid/rsp_ready carrying rsp_plain_byte; skip and restart requests
//   only move the keystream and yield nothing.
//   A response is presented the cycle after its request is taken, unless the
//   receiver stalls. Throughput: one request per cycle while the skid register
//   is empty; the keystream update and the byte transform are a single pass of
//   logic ahead of the response register. When the receiver stalls, the
//   response register holds and one more response lands in a skid register;
//   req_ready drops only while that skid register is full.
//   Reset (synchronous, active high) clears both response slots, loads the
//   keystream start state (index A 0, index B 8, swap 0, number 0) and
//   clears all keys, start_index and encrypt_enable.
//   Configuration: csr_wr_en writes csr_wdata to register csr_index in the
//   same edge; write only while no request is in flight.
module pack_byte_stream_decryptor_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_command,
   input  logic [7:0]                           req_cipher_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_plain_byte,
   input  logic                                 csr_wr_en,
   input  logic [pbsd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pbsd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IW = pbsd_pkg::KEY_IDX_W;
   localparam int NW = pbsd_pkg::NUM_W;

   logic [pbsd_pkg::KEY_BITS-1:0] key_a_ff, key_b_ff;
   logic [NW-1:0]                 start_index_ff;
   logic                          encrypt_enable_ff;

   logic [IW-1:0] index_a_ff, index_a_in;
   logic [IW-1:0] index_b_ff, index_b_in;
   logic [NW-1:0] number_ff, number_in;
   logic          swap_ff, swap_in;

   logic          rsp_valid_ff, skid_valid_ff;
   logic [7:0]    rsp_data_ff, skid_data_ff;

   logic          accept;
   logic          produce;
   logic          advance;
   logic [7:0]    plain_in;
   logic [7:0]    mix;
   logic [IW:0]   a_next, b_next;
   logic [NW-1:0] num_next;
   pbsd_pkg::command_type cmd;

   assign cmd       = pbsd_pkg::command_type'(req_command);
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign produce   = accept && (cmd == pbsd_pkg::CMD_DECRYPT);
   assign advance   = accept && encrypt_enable_ff &&
                      (cmd == pbsd_pkg::CMD_DECRYPT || cmd == pbsd_pkg::CMD_SKIP);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_byte = rsp_data_ff;

   always_comb begin
      mix = key_b_ff[8*index_b_ff +: 8] ^ {1'b0, number_ff} ^ req_cipher_byte;
      if (swap_ff) begin
         mix = {mix[3:0], mix[7:4]};
      end
      mix = mix ^ key_a_ff[8*index_a_ff +: 8];
      plain_in = encrypt_enable_ff ? mix : req_cipher_byte;
   end

   always_comb begin
      a_next   = {1'b0, index_a_ff} + (IW+1)'(1);
      b_next   = {1'b0, index_b_ff} + (IW+1)'(1);
      num_next = number_ff + pbsd_pkg::NUM_STEP;
      index_a_in = index_a_ff;
      index_b_in = index_b_ff;
      number_in  = number_ff;
      swap_in    = swap_ff;
      if (accept && cmd == pbsd_pkg::CMD_RESTART) begin
         index_a_in = pbsd_pkg::INDEX_A_START;
         index_b_in = pbsd_pkg::INDEX_B_START;
         number_in  = start_index_ff;
         swap_in    = 1'b0;
      end else if (advance) begin
         if (a_next <= pbsd_pkg::INDEX_A_LIMIT) begin
            index_a_in = a_next[IW-1:0];
            if (b_next > pbsd_pkg::INDEX_B_WRAP) begin
               index_b_in = '0;
               swap_in    = !swap_ff;
            end else begin
               index_b_in = b_next[IW-1:0];
            end
         end else if (b_next <= pbsd_pkg::INDEX_B_HOLD) begin
            index_a_in = '0;
            index_b_in = b_next[IW-1:0];
            swap_in    = !swap_ff;
         end else begin
            number_in = num_next;
            if (swap_ff) begin
               swap_in    = 1'b0;
               index_a_in = IW'(pbsd_pkg::mod7(num_next));
               index_b_in = pbsd_pkg::mod12(num_next) + IW'(2);
            end else begin
               swap_in    = 1'b1;
               index_b_in = IW'(pbsd_pkg::mod7(num_next));
               index_a_in = pbsd_pkg::mod12(num_next) + IW'(3);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_a_ff          <= '0;
         key_b_ff          <= '0;
         start_index_ff    <= '0;
         encrypt_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pbsd_pkg::CSR_KEY_A_LOW:
               key_a_ff[pbsd_pkg::CSR_DATA_W-1:0] <= csr_wdata;
            pbsd_pkg::CSR_KEY_A_HIGH:
               key_a_ff[pbsd_pkg::KEY_BITS-1:pbsd_pkg::CSR_DATA_W] <= csr_wdata;
            pbsd_pkg::CSR_KEY_B_LOW:
               key_b_ff[pbsd_pkg::CSR_DATA_W-1:0] <= csr_wdata;
            pbsd_pkg::CSR_KEY_B_HIGH:
               key_b_ff[pbsd_pkg::KEY_BITS-1:pbsd_pkg::CSR_DATA_W] <= csr_wdata;
            pbsd_pkg::CSR_START_INDEX:    start_index_ff    <= csr_wdata[NW-1:0];
            pbsd_pkg::CSR_ENCRYPT_ENABLE: encrypt_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_a_ff <= pbsd_pkg::INDEX_A_START;
         index_b_ff <= pbsd_pkg::INDEX_B_START;
         number_ff  <= '0;
         swap_ff    <= 1'b0;
      end else begin
         index_a_ff <= index_a_in;
         index_b_ff <= index_b_in;
         number_ff  <= number_in;
         swap_ff    <= swap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            rsp_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= produce;
            if (produce) begin
               rsp_data_ff <= plain_in;
            end
         end
      end else if (produce) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= plain_in;
      end
   end

   // skid slot is only ever filled behind a held response
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot full with empty response register");

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_valid_ff && !rsp_ready |=> skid_valid_ff && $stable(skid_data_ff))
      else $error("skid slot changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      accept && cmd == pbsd_pkg::CMD_RESTART |=>
         index_a_ff == pbsd_pkg::INDEX_A_START && index_b_ff == pbsd_pkg::INDEX_B_START &&
         !swap_ff)
      else $error("restart did not load start state");

   assert property (@(posedge clock) disable iff (reset)
      !encrypt_enable_ff && !(accept && cmd == pbsd_pkg::CMD_RESTART) |=>
         $stable(index_a_ff) && $stable(index_b_ff) && $stable(number_ff) && $stable(swap_ff))
      else $error("keystream moved in plain mode");

   assert property (@(posedge clock) disable iff (reset) index_b_ff <= IW'(13))
      else $error("index B out of range");

endmodule

### test/pack_byte_stream_decryptor_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pack_byte_stream_decryptor_core: queued requests, a clocked
// driver and response monitor, and an in-bench keystream predictor compared byte by byte.
// Depends on pbsd_pkg and the core RTL only.
module pack_byte_stream_decryptor_core_tb;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int LONG_STALL_CYCLES = 60;

   typedef struct {
      pbsd_pkg::command_type command;
      logic [7:0]            cipher;
   } request_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [1:0]                       req_command = pbsd_pkg::CMD_NONE;
   logic [7:0]                       req_cipher_byte = 8'h00;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [7:0]                       rsp_plain_byte;
   logic                             csr_wr_en = 1'b0;
   logic [pbsd_pkg::CSR_INDEX_W-1:0] csr_index = pbsd_pkg::CSR_KEY_A_LOW;
   logic [pbsd_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   request_type request_q[$];
   logic [7:0]  plain_expected_q[$];
   int          requests_queued = 0;
   int          requests_taken = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          long_stall_requests = 0;
   int          long_stall_served = 0;
   int          stall_left = 0;

   // keystream mirror and register copies
   logic [pbsd_pkg::KEY_BITS-1:0] key_a_table = '0;
   logic [pbsd_pkg::KEY_BITS-1:0] key_b_table = '0;
   logic [pbsd_pkg::NUM_W-1:0]    restart_num = '0;
   logic                          crypt_on = 1'b0;
   logic [3:0]                    pos_a = pbsd_pkg::INDEX_A_START;
   logic [3:0]                    pos_b = pbsd_pkg::INDEX_B_START;
   logic [pbsd_pkg::NUM_W-1:0]    roll_num = '0;
   logic                          swap_on = 1'b0;

   pack_byte_stream_decryptor_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_cipher_byte (req_cipher_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_plain_byte  (rsp_plain_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic advance_keystream();
      int a;
      int b;
      int n;
      a = pos_a + 1;
      b = pos_b + 1;
      if (a <= 15) begin
         if (b > 12) begin
            b = 0;
            swap_on = !swap_on;
         end
      end else if (b <= 8) begin
         a = 0;
         swap_on = !swap_on;
      end else begin
         n = (roll_num + 2) % 128;
         roll_num = n[pbsd_pkg::NUM_W-1:0];
         if (swap_on) begin
            swap_on = 1'b0;
            a = n % 7;
            b = n % 12 + 2;
         end else begin
            swap_on = 1'b1;
            b = n % 7;
            a = n % 12 + 3;
         end
      end
      pos_a = a[3:0];
      pos_b = b[3:0];
   endtask

   task automatic predict_request(pbsd_pkg::command_type cmd, logic [7:0] cipher);
      logic [7:0] t;
      case (cmd)
         pbsd_pkg::CMD_DECRYPT: begin
            t = cipher;
            if (crypt_on) begin
               t = key_b_table[8*pos_b +: 8] ^ {1'b0, roll_num} ^ cipher;
               if (swap_on)
                  t = {t[3:0], t[7:4]};
               t = t ^ key_a_table[8*pos_a +: 8];
               advance_keystream();
            end
            plain_expected_q.push_back(t);
         end
         pbsd_pkg::CMD_SKIP: begin
            if (crypt_on)
               advance_keystream();
         end
         pbsd_pkg::CMD_RESTART: begin
            pos_a = pbsd_pkg::INDEX_A_START;
            pos_b = pbsd_pkg::INDEX_B_START;
            swap_on = 1'b0;
            roll_num = restart_num;
         end
         default: ;
      endcase
   endtask

   function automatic void queue_request(pbsd_pkg::command_type cmd, logic [7:0] cipher);
      request_q.push_back('{cmd, cipher});
      requests_queued++;
   endfunction

   always @(posedge clock) begin
      request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_request(pbsd_pkg::command_type'(req_command), req_cipher_byte);
            requests_taken++;
         end
         if (!req_valid || req_ready) begin
            if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = request_q.pop_front();
               req_valid <= 1'b1;
               req_command <= nxt.command;
               req_cipher_byte <= nxt.cipher;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (plain_expected_q.size() == 0) begin
               $error("plain_byte: expected none, actual %02h", rsp_plain_byte);
               mismatch_count++;
            end else begin
               want = plain_expected_q.pop_front();
               if (rsp_plain_byte !== want) begin
                  $error("plain_byte: expected %02h, actual %02h", want, rsp_plain_byte);
                  mismatch_count++;
               end
            end
         end
         if (long_stall_served != long_stall_requests) begin
            long_stall_served = long_stall_requests;
            stall_left = LONG_STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      do
         @(posedge clock);
      while (requests_taken != requests_queued || plain_expected_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(pbsd_pkg::csr_index_type idx,
                                 logic [pbsd_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic load_settings(logic [63:0] a_lo, logic [63:0] a_hi, logic [63:0] b_lo,
                                logic [63:0] b_hi, logic [pbsd_pkg::NUM_W-1:0] start,
                                logic enc);
      write_register(pbsd_pkg::CSR_KEY_A_LOW, a_lo);
      write_register(pbsd_pkg::CSR_KEY_A_HIGH, a_hi);
      write_register(pbsd_pkg::CSR_KEY_B_LOW, b_lo);
      write_register(pbsd_pkg::CSR_KEY_B_HIGH, b_hi);
      write_register(pbsd_pkg::CSR_START_INDEX, pbsd_pkg::CSR_DATA_W'(start));
      write_register(pbsd_pkg::CSR_ENCRYPT_ENABLE, pbsd_pkg::CSR_DATA_W'(enc));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      key_a_table = {a_hi, a_lo};
      key_b_table = {b_hi, b_lo};
      restart_num = start;
      crypt_on = enc;
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // mostly restart, skip-to-offset, then a run of decrypts; the rest is loose noise
   task automatic queue_random_traffic(int target);
      int counted;
      int skips;
      int bytes;
      pbsd_pkg::command_type cmd;
      counted = 0;
      while (counted < target) begin
         if ($urandom_range(0, 99) < 65) begin
            skips = $urandom_range(0, 24);
            bytes = $urandom_range(1, 24);
            queue_request(pbsd_pkg::CMD_RESTART, 8'($urandom));
            repeat (skips) queue_request(pbsd_pkg::CMD_SKIP, 8'($urandom));
            repeat (bytes) queue_request(pbsd_pkg::CMD_DECRYPT, 8'($urandom));
            counted += 1 + bytes + (crypt_on ? skips : 0);
         end else begin
            cmd = pbsd_pkg::command_type'($urandom_range(0, 3));
            queue_request(cmd, 8'($urandom));
            if (cmd == pbsd_pkg::CMD_DECRYPT || cmd == pbsd_pkg::CMD_RESTART ||
                (cmd == pbsd_pkg::CMD_SKIP && crypt_on))
               counted++;
         end
      end
   endtask

   initial begin
      logic [63:0] ka_lo;
      logic [63:0] ka_hi;
      logic [63:0] kb_lo;
      logic [63:0] kb_hi;
      send_idle_pct = 36;
      recv_idle_pct = 61;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // pass-through from reset: no keystream movement
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'h00);
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'hFF);
      queue_request(pbsd_pkg::CMD_SKIP, 8'h12);
      queue_request(pbsd_pkg::CMD_NONE, 8'hC3);
      queue_request(pbsd_pkg::CMD_RESTART, 8'h77);
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'h5A);
      wait_drained();

      ka_lo = random_word();
      ka_hi = random_word();
      kb_lo = random_word();
      kb_hi = random_word();
      load_settings(ka_lo, ka_hi, kb_lo, kb_hi, 7'd127, 1'b1);
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'h00);
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'hFF);
      queue_request(pbsd_pkg::CMD_SKIP, 8'h00);
      queue_request(pbsd_pkg::CMD_NONE, 8'hFF);
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'hA5);
      queue_request(pbsd_pkg::CMD_RESTART, 8'h00);
      queue_request(pbsd_pkg::CMD_SKIP, 8'hFF);
      queue_request(pbsd_pkg::CMD_SKIP, 8'h3C);
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'h3C);
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'h81);
      wait_drained();

      // restart takes effect in plain mode too
      load_settings(ka_lo, ka_hi, kb_lo, kb_hi, 7'd99, 1'b0);
      queue_request(pbsd_pkg::CMD_RESTART, 8'h00);
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'h66);
      wait_drained();
      load_settings(ka_lo, ka_hi, kb_lo, kb_hi, 7'd99, 1'b1);
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'h00);
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'hFF);
      queue_request(pbsd_pkg::CMD_DECRYPT, 8'h96);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         case (p / 2)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (p)
            1: load_settings('1, '1, '1, '1, 7'd127, 1'b1);
            2: load_settings('0, '0, '0, '0, 7'd0, 1'b1);
            3: load_settings(random_word(), random_word(), random_word(), random_word(),
                             7'd126, 1'b0);
            4: load_settings(random_word(), random_word(), random_word(), random_word(),
                             7'd126, 1'b1);
            default: load_settings(random_word(), random_word(), random_word(),
                                   random_word(), 7'($urandom), 1'b1);
         endcase
         queue_random_traffic(90);
         wait_drained();
      end

      // hold the response side long enough for the core to back up its input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings(random_word(), random_word(), random_word(), random_word(),
                    7'($urandom), 1'b1);
      long_stall_requests++;
      queue_request(pbsd_pkg::CMD_RESTART, 8'h00);
      repeat (40) queue_request(pbsd_pkg::CMD_DECRYPT, 8'($urandom));
      wait_drained();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
